[sv/tcw_pkg.sv]
// Shared constants and types for the text console character writer.
// No dependencies; imported by tcw_ctrl and the top level of the block.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = $clog2(CELL_COUNT);

    localparam int CELL_W  = 16;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int CMD_W   = 2;
    localparam int INDEX_W = 11;
    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 7;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0]  BLANK_CHAR     = 8'h20;
    localparam logic [CHAR_W-1:0]  NEWLINE_CHAR   = 8'h0A;
    localparam logic [CHAR_W-1:0]  BACKSPACE_CHAR = 8'h08;
    localparam logic [COLOR_W-1:0] RESET_COLOR    = 8'h0F;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] wdata;
    } mem_req_t;

endpackage

[sv/tcw_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[sv/tcw_ctrl.sv]
// Command sequencer: cursor update, cell writes, reads and clearing sweeps.
// Depends on tcw_pkg; drives the screen RAM through a mem_req_t request.
`timescale 1ns / 1ps

module tcw_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [tcw_pkg::CMD_W-1:0]       command,
    input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]     cell_index,
    input  logic [tcw_pkg::COLOR_W-1:0]     text_color,
    input  logic [tcw_pkg::CELL_W-1:0]      mem_rdata,
    output tcw_pkg::mem_req_t               mem_req,
    output logic                            busy,
    output logic                            done,
    output logic [tcw_pkg::CELL_W-1:0]      cell_value,
    output logic [tcw_pkg::ROW_W-1:0]       cursor_row,
    output logic [tcw_pkg::COL_W-1:0]       cursor_col,
    output logic                            screen_cleared
);

    import tcw_pkg::*;

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_READ
    } state_t;

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);

    state_t              state_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ADDR_W-1:0]   sweep_cnt_reg;
    logic [COLOR_W-1:0]  sweep_color_reg;
    logic                report_reg;
    logic                rd_oob_reg;
    logic                done_reg;
    logic                cleared_reg;
    logic [CELL_W-1:0]   value_reg;

    logic                accept;
    logic [ROW_W:0]      row_next;
    logic [COL_W:0]      col_next;
    logic [COL_W-1:0]    wr_col;
    logic [CHAR_W-1:0]   wr_char;
    logic                wr_en;
    logic                overflow;
    logic [ADDR_W-1:0]   put_addr;

    assign accept = start && (state_reg == S_IDLE);

    // Cursor step for a put command
    always_comb
    begin
        row_next = {1'b0, row_reg};
        col_next = {1'b0, col_reg};
        wr_col   = col_reg;
        wr_char  = char_code;
        wr_en    = 1'b0;
        priority if (char_code == NEWLINE_CHAR)
        begin
            row_next = {1'b0, row_reg} + 1'b1;
            col_next = '0;
        end
        else if (char_code == BACKSPACE_CHAR)
        begin
            if (col_reg != '0)
            begin
                col_next = {1'b0, col_reg} - 1'b1;
                wr_col   = col_reg - 1'b1;
                wr_char  = BLANK_CHAR;
                wr_en    = 1'b1;
            end
        end
        else
        begin
            wr_en = 1'b1;
            if (({1'b0, col_reg} + 1'b1) >= (COL_W+1)'(COLUMNS))
            begin
                col_next = '0;
                row_next = {1'b0, row_reg} + 1'b1;
            end
            else
            begin
                col_next = {1'b0, col_reg} + 1'b1;
            end
        end
        overflow = row_next >= (ROW_W+1)'(ROWS);
        put_addr = ADDR_W'(32'(row_reg) * COLUMNS + 32'(wr_col));
    end

    always_comb
    begin
        if (state_reg == S_SWEEP)
        begin
            mem_req.we    = 1'b1;
            mem_req.addr  = sweep_cnt_reg;
            mem_req.wdata = {sweep_color_reg, BLANK_CHAR};
        end
        else if (accept && (command == CMD_PUT) && wr_en)
        begin
            mem_req.we    = 1'b1;
            mem_req.addr  = put_addr;
            mem_req.wdata = {text_color, wr_char};
        end
        else
        begin
            mem_req.we    = 1'b0;
            mem_req.addr  = ADDR_W'(cell_index);
            mem_req.wdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_SWEEP;
            row_reg         <= '0;
            col_reg         <= '0;
            sweep_cnt_reg   <= '0;
            sweep_color_reg <= RESET_COLOR;
            report_reg      <= 1'b0;
            rd_oob_reg      <= 1'b0;
            done_reg        <= 1'b0;
            cleared_reg     <= 1'b0;
            value_reg       <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_SWEEP:
                begin
                    sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                    if (sweep_cnt_reg == LAST_CELL)
                    begin
                        // reset sweep finishes silently
                        state_reg     <= S_IDLE;
                        sweep_cnt_reg <= '0;
                        done_reg      <= report_reg;
                        cleared_reg   <= report_reg;
                        value_reg     <= '0;
                    end
                end
                S_READ:
                begin
                    value_reg   <= rd_oob_reg ? '0 : mem_rdata;
                    cleared_reg <= 1'b0;
                    done_reg    <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        unique case (command)
                            CMD_PUT:
                            begin
                                if (overflow)
                                begin
                                    row_reg         <= '0;
                                    col_reg         <= '0;
                                    sweep_cnt_reg   <= '0;
                                    sweep_color_reg <= text_color;
                                    report_reg      <= 1'b1;
                                    state_reg       <= S_SWEEP;
                                end
                                else
                                begin
                                    row_reg     <= row_next[ROW_W-1:0];
                                    col_reg     <= col_next[COL_W-1:0];
                                    done_reg    <= 1'b1;
                                    cleared_reg <= 1'b0;
                                    value_reg   <= '0;
                                end
                            end
                            CMD_READ:
                            begin
                                rd_oob_reg <= 32'(cell_index) >= CELL_COUNT;
                                state_reg  <= S_READ;
                            end
                            CMD_CLEAR:
                            begin
                                row_reg         <= '0;
                                col_reg         <= '0;
                                sweep_cnt_reg   <= '0;
                                sweep_color_reg <= text_color;
                                report_reg      <= 1'b1;
                                state_reg       <= S_SWEEP;
                            end
                            default:
                            begin
                                done_reg    <= 1'b1;
                                cleared_reg <= 1'b0;
                                value_reg   <= '0;
                            end
                        endcase
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign cell_value     = value_reg;
    assign cursor_row     = row_reg;
    assign cursor_col     = col_reg;
    assign screen_cleared = cleared_reg;

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(row_reg) < ROWS) && (32'(col_reg) < COLUMNS))
        else $error("cursor out of screen");

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (command == CMD_READ)) |=> !done_reg ##1 done_reg)
        else $error("read result not two cycles after request");

    a_cleared_home: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && cleared_reg) |-> (row_reg == '0) && (col_reg == '0))
        else $error("cleared screen with cursor away from home");

    a_sweep_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> mem_req.we && (mem_req.wdata[CHAR_W-1:0] == BLANK_CHAR))
        else $error("sweep cycle without blank write");

    a_value_only_read: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (value_reg != '0)) |-> ($past(state_reg) == S_READ))
        else $error("nonzero cell value on a non-read result");

endmodule

[sv/text_console_char_writer_core.sv]
// Top level of the text console character writer: color register, sequencer, screen RAM.
// Depends on tcw_pkg, tcw_ctrl and tcw_ram.
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// command   in         start & !busy              command, char_code, cell_index
// result    out        done (one-cycle strobe)    cell_value, cursor_row, cursor_col,
//                                                 screen_cleared
// config    in         cfg_valid & cfg_ready      cfg_data (text_color)
//
// Put without clear: result in the cycle after the request, and busy stays low.
// Read: the RAM registers the read data, then the sequencer registers it as the result.
// Clear, or a put that runs past the last row: the sweep writes one cell per cycle over
// all CELL_COUNT (2000) cells, result strobed right after the sweep.
// After reset the same sweep runs with busy high and gives no result; config is taken
// at any time. The receiver cannot stall: done lasts one cycle.

module text_console_char_writer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [tcw_pkg::CMD_W-1:0]           command,
    input  logic [tcw_pkg::CHAR_W-1:0]          char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]         cell_index,
    output logic                                done,
    output logic [tcw_pkg::CELL_W-1:0]          cell_value,
    output logic [tcw_pkg::ROW_FIELD_W-1:0]     cursor_row,
    output logic [tcw_pkg::COL_FIELD_W-1:0]     cursor_col,
    output logic                                screen_cleared,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tcw_pkg::COLOR_W-1:0]         cfg_data
);

    import tcw_pkg::*;

    logic [COLOR_W-1:0] color_reg;
    mem_req_t           mem_req;
    logic [CELL_W-1:0]  mem_rdata;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= RESET_COLOR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            color_reg <= cfg_data;
        end
    end

    tcw_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .command        (command),
        .char_code      (char_code),
        .cell_index     (cell_index),
        .text_color     (color_reg),
        .mem_rdata      (mem_rdata),
        .mem_req        (mem_req),
        .busy           (busy),
        .done           (done),
        .cell_value     (cell_value),
        .cursor_row     (row),
        .cursor_col     (col),
        .screen_cleared (screen_cleared)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .clk   (clk),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

    assign cursor_row = ROW_FIELD_W'(row);
    assign cursor_col = COL_FIELD_W'(col);

endmodule
